// ----- design/mkde_pkg.sv -----
// ----------------------------------------------------------------------------
// mkde_pkg
// Shared constants for the multi-key debounce event block.
// ----------------------------------------------------------------------------
package mkde_pkg;

  localparam int unsigned KEYS_DEFAULT = 5;
  localparam int unsigned CNT_W        = 8;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MIN_RESET = CNT_W'(4);

endpackage

// ----- design/mkde_lane.sv -----
// ----------------------------------------------------------------------------
// mkde_lane
// Press counter and held flag of one key, with its fire candidate.
// ----------------------------------------------------------------------------
module mkde_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       pressed_i,
  input  logic [mkde_pkg::CNT_W-1:0] press_min_i,
  output logic                       cand_o
);

  logic [mkde_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                       held_q, held_d;

  assign cnt_inc = (cnt_q == mkde_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign cand_o  = pressed_i && !held_q && (cnt_inc >= press_min_i);

  always_comb begin
    cnt_d  = cnt_q;
    held_d = held_q;
    if (step_i) begin
      if (!pressed_i) begin
        cnt_d  = '0;
        held_d = 1'b0;
      end else if (cand_o) begin
        cnt_d  = '0;
        held_d = 1'b1;
      end else begin
        cnt_d  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      held_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- design/mkde_merge.sv -----
// ----------------------------------------------------------------------------
// mkde_merge
// Priority merge of the lane candidates into an event code and update mask.
// ----------------------------------------------------------------------------
module mkde_merge #(
  parameter int unsigned NUM_KEYS = mkde_pkg::KEYS_DEFAULT,
  parameter int unsigned EVENT_W  = $clog2(NUM_KEYS + 1)
) (
  input  logic [NUM_KEYS-1:0] cand_i,
  output logic [NUM_KEYS-1:0] upd_mask_o,
  output logic [EVENT_W-1:0]  event_o
);

  logic [NUM_KEYS:0] below;

  // A lane is updated when no lane of lower index fires.
  always_comb begin
    below[0] = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      below[i+1]    = below[i] | cand_i[i];
      upd_mask_o[i] = !below[i];
    end
  end

  always_comb begin
    event_o = EVENT_W'(NUM_KEYS);
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (cand_i[i]) begin
        event_o = EVENT_W'(i);
      end
    end
  end

endmodule

// ----- design/multi_key_debounce_event.sv -----
// ----------------------------------------------------------------------------
// multi_key_debounce_event
// Counter-based debouncer for several keys that reports one key event per
// sample word.
// ----------------------------------------------------------------------------
// Each input word is one sample of the key bits and yields one output word:
// the index of the lowest key that completed press_minimum consecutive
// pressed samples while not already held, or NUM_KEYS when no key fired.
// Keys above the firing key keep their state for that sample. The block
// takes one word per clock cycle while the output side is not stalled, and
// registers the event code; every key has its own counter lane, and a
// priority stage picks the winning lane in the same cycle. A word is
// accepted whenever the output register is empty or is being read.
module multi_key_debounce_event #(
  parameter int unsigned NUM_KEYS = mkde_pkg::KEYS_DEFAULT,
  parameter int unsigned EVENT_W  = $clog2(NUM_KEYS + 1),
  parameter int unsigned IN_W     = ((NUM_KEYS + 7) / 8) * 8,
  parameter int unsigned OUT_W    = ((EVENT_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mkde_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [IN_W-1:0]            s_axis_tdata,  // key_bits
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata   // key_event
);

  logic [mkde_pkg::CNT_W-1:0] press_min_q;
  logic [NUM_KEYS-1:0]        cand, upd_mask, step;
  logic [EVENT_W-1:0]         event_w;
  logic [EVENT_W-1:0]         event_q;
  logic                       out_valid_q;
  logic                       accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_min_q <= mkde_pkg::MIN_RESET;
    end else if (cfg_we_i) begin
      press_min_q <= cfg_wdata_i;
    end
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    mkde_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step[g]),
      .pressed_i   (s_axis_tdata[g]),
      .press_min_i (press_min_q),
      .cand_o      (cand[g])
    );
  end

  mkde_merge #(
    .NUM_KEYS (NUM_KEYS),
    .EVENT_W  (EVENT_W)
  ) u_merge (
    .cand_i     (cand),
    .upd_mask_o (upd_mask),
    .event_o    (event_w)
  );

  assign step = upd_mask & {NUM_KEYS{accept}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(event_q);

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (event_q <= EVENT_W'(NUM_KEYS)))
    else $error("key event code out of range");

  a_one_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(step & cand))
    else $error("more than one lane fired on one sample");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted sample produced no output word");

endmodule

// ----- test/multi_key_debounce_event_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_key_debounce_event_tb
// Self-checking testbench for the multi-key debounce event block.
// ----------------------------------------------------------------------------
// A driver feeds key sample words from a queue and a monitor checks every
// output word against a cycle-free model of the per-key press counters and
// held flags. The run walks through several press_minimum settings. Each
// setting gets key patterns held for about the debounce length, plus short
// noise runs. Phases with random gaps on the input side, random stalls on
// the output side, and one long output hold-off exercise the handshake.
// ----------------------------------------------------------------------------
module multi_key_debounce_event_tb;

  localparam int unsigned KEYS         = mkde_pkg::KEYS_DEFAULT;
  localparam int unsigned CNT_W        = mkde_pkg::CNT_W;
  localparam int unsigned EVENT_W      = $clog2(KEYS + 1);
  localparam int unsigned IN_W         = ((KEYS + 7) / 8) * 8;
  localparam int unsigned OUT_W        = ((EVENT_W + 7) / 8) * 8;
  localparam logic [EVENT_W-1:0] QUIET_CODE = EVENT_W'(KEYS);
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NUM_DIRECTED = 22;
  localparam logic [KEYS-1:0] DIRECTED [NUM_DIRECTED] = '{
    5'b00000, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111,
    5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11110, 5'b00000,
    5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b10000, 5'b00001,
    5'b00001, 5'b00001, 5'b01010, 5'b00000
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [CNT_W-1:0]   press_cnt [KEYS];
  logic [KEYS-1:0]    held_keys;
  logic [CNT_W-1:0]   press_min;
  logic [EVENT_W-1:0] expected_events [$];
  logic [KEYS-1:0]    pending_samples [$];

  logic        in_fire       = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active   = 1'b0;
  int unsigned hold_cycles   = 0;
  logic        holding;
  int unsigned cycle_count   = 0;
  int unsigned err_count     = 0;
  int unsigned words_in      = 0;
  int unsigned key_events    = 0;

  assign holding = hold_active && (hold_cycles < HOLD_LEN);

  multi_key_debounce_event uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [EVENT_W-1:0] debounce_sample(input logic [KEYS-1:0] keys);
    logic [EVENT_W-1:0] fired;
    fired = QUIET_CODE;
    for (int k = 0; k < KEYS && fired == QUIET_CODE; k++) begin
      if (keys[k]) begin
        if (press_cnt[k] != mkde_pkg::CNT_MAX) press_cnt[k] = press_cnt[k] + 1'b1;
        if (press_cnt[k] >= press_min && !held_keys[k]) begin
          held_keys[k] = 1'b1;
          press_cnt[k] = '0;
          fired = EVENT_W'(k);
        end
      end else begin
        held_keys[k] = 1'b0;
        press_cnt[k] = '0;
      end
    end
    return fired;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic write_press_min(input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    press_min = value;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic queue_runs(input int unsigned count, input int unsigned max_run);
    int unsigned made;
    int unsigned len;
    logic [KEYS-1:0] pattern;
    made = 0;
    while (made < count) begin
      pattern = KEYS'($urandom_range(2 ** KEYS - 1));
      if ($urandom_range(4) == 0) len = 1;
      else len = $urandom_range(max_run, 1);
      repeat (len) pending_samples.push_back(pattern);
      if ($urandom_range(5) == 0) pending_samples.push_back('0);
      made += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(pending_samples.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk_i) begin
    if (holding) hold_cycles <= hold_cycles + 1;
  end

  always @(posedge clk_i) begin
    logic [EVENT_W-1:0] want;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_events.push_back(debounce_sample(s_axis_tdata[KEYS-1:0]));
      words_in++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected output word %0d", m_axis_tdata));
      end else begin
        want = expected_events.pop_front();
        if (want != QUIET_CODE) key_events++;
        if (m_axis_tdata != OUT_W'(want))
          report_mismatch($sformatf("key_event got %0d, expected %0d", m_axis_tdata, want));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL multi_key_debounce_event");
      $finish;
    end
  end

  initial begin
    foreach (press_cnt[k]) press_cnt[k] = '0;
    held_keys = '0;
    press_min = mkde_pkg::MIN_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value of press_minimum, fixed patterns, no idling.
    set_idling(0, 0);
    foreach (DIRECTED[i]) pending_samples.push_back(DIRECTED[i]);
    wait_drained();

    write_press_min(CNT_W'(1));
    queue_runs(150, 4);
    wait_drained();

    // A minimum of zero fires on the first pressed sample.
    write_press_min(CNT_W'(0));
    set_idling(51, 0);
    queue_runs(150, 3);
    wait_drained();

    // The output side holds off while the input keeps offering words.
    write_press_min(CNT_W'(3));
    set_idling(0, 51);
    queue_runs(150, 6);
    @(posedge clk_i);
    hold_active = 1'b1;
    wait_drained();

    write_press_min(mkde_pkg::CNT_MAX);
    set_idling(8, 8);
    repeat (300) pending_samples.push_back(5'b10101);
    queue_runs(150, 258);
    wait_drained();

    write_press_min(CNT_W'($urandom_range(10, 2)));
    set_idling(20, 30);
    queue_runs(100, 12);
    wait_drained();

    write_press_min(mkde_pkg::MIN_RESET);
    set_idling(0, 0);
    queue_runs(100, 7);
    wait_drained();

    $display("Checked %0d sample words with %0d key events across seven press_minimum",
             words_in, key_events);
    $display("settings, with input gaps, output stalls and a %0d-cycle output hold-off.",
             HOLD_LEN);
    if (err_count == 0) begin
      $display("PASS multi_key_debounce_event");
    end else begin
      $display("FAIL multi_key_debounce_event");
    end
    $finish;
  end

endmodule
